// ===== rtl/i2c_master_bit_engine_assert.svh =====
// Assertion macros for the I2C master bit engine.
// Needs clk_i and rst_ni in the scope that uses them; no other dependencies.
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// Checked on every rising clock edge outside of reset.
`define I2CM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define I2CM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/i2cm_pkg.sv =====
// Shared types and constants of the I2C master bit engine.
// No dependencies; used by i2cm_cfg, i2cm_seq and the top level.
`default_nettype none

package i2cm_pkg;

  localparam int unsigned DelayW = 16;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SHORT = 2'd0;
  localparam logic [1:0] CFG_LONG  = 2'd1;
  localparam logic [1:0] CFG_WAIT  = 2'd2;

  localparam logic [DelayW-1:0] SHORT_RESET = 16'd4;
  localparam logic [DelayW-1:0] LONG_RESET  = 16'd8;
  localparam logic [DelayW-1:0] WAIT_RESET  = 16'd0;

  typedef enum logic [2:0] {
    CMD_START      = 3'd0,
    CMD_START_BYTE = 3'd1,
    CMD_START_ADDR = 3'd2,
    CMD_STOP       = 3'd3,
    CMD_WRITE      = 3'd4,
    CMD_WRITE_NACK = 3'd5,
    CMD_WRITE16    = 3'd6,
    CMD_READ       = 3'd7
  } cmd_e;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_S_SCLHI  = 5'd1,
    PH_S_SDALO  = 5'd2,
    PH_W_SCLLO  = 5'd3,
    PH_W_DATA   = 5'd4,
    PH_W_SCLHI  = 5'd5,
    PH_W_TAIL   = 5'd6,
    PH_A_SDAHI  = 5'd7,
    PH_A_SCLHI  = 5'd8,
    PH_A_SAMPLE = 5'd9,
    PH_A_SCLLO  = 5'd10,
    PH_P_SDALO  = 5'd11,
    PH_P_SCLHI  = 5'd12,
    PH_P_SDAHI  = 5'd13,
    PH_R_SCLLO  = 5'd14,
    PH_R_SCLHI  = 5'd15,
    PH_R_REL    = 5'd16,
    PH_R_ACK    = 5'd17,
    PH_R_CLKHI  = 5'd18,
    PH_R_CLKLO  = 5'd19
  } phase_e;

  // Effective hold lengths handed from the register block to the sequencer.
  typedef struct packed {
    logic [DelayW-1:0] short_ticks;
    logic [DelayW-1:0] long_ticks;
    logic [DelayW-1:0] bit_ticks;
  } hold_t;

  typedef struct packed {
    phase_e            phase;
    logic [DelayW-1:0] cnt;
    logic [3:0]        bit_idx;
    logic [15:0]       tx;
    logic [7:0]        rx;
    logic              scl;
    logic              sda;
    cmd_e              cmd;
    logic              ack_seen;
    logic              ack_to_send;
    logic              second_byte;
  } seq_state_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic       acked;
    logic [7:0] read_byte;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/i2cm_cfg.sv =====
// Delay configuration registers and the effective hold lengths derived from them.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [i2cm_pkg::DelayW-1:0]   cfg_data_i,
  output i2cm_pkg::hold_t                    hold_o
);

  logic [i2cm_pkg::DelayW-1:0] short_q, long_q, wait_q;
  logic [i2cm_pkg::DelayW:0]   bit_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= i2cm_pkg::SHORT_RESET;
      long_q  <= i2cm_pkg::LONG_RESET;
      wait_q  <= i2cm_pkg::WAIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        i2cm_pkg::CFG_SHORT: short_q <= cfg_data_i;
        i2cm_pkg::CFG_LONG:  long_q  <= cfg_data_i;
        i2cm_pkg::CFG_WAIT:  wait_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A zero hold still lasts one tick; the data bit hold saturates.
  always_comb begin
    hold_o.short_ticks = (short_q == '0) ? i2cm_pkg::DelayW'(1) : short_q;
    hold_o.long_ticks  = (long_q == '0) ? i2cm_pkg::DelayW'(1) : long_q;
    bit_sum = {1'b0, hold_o.short_ticks} + {1'b0, wait_q};
    hold_o.bit_ticks = bit_sum[i2cm_pkg::DelayW] ? '1 : bit_sum[i2cm_pkg::DelayW-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/i2cm_seq.sv =====
// Bus sequencer of the I2C master: state registers and the one-tick update logic.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_seq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic            kind_i,
  input  wire logic [2:0]      command_i,
  input  wire logic [15:0]     data_i,
  input  wire logic [6:0]      address_i,
  input  wire logic            rw_flag_i,
  input  wire logic            send_ack_i,
  input  wire logic            sda_in_i,
  input  wire i2cm_pkg::hold_t hold_i,
  output i2cm_pkg::res_t       res_o,
  output logic                 busy_o
);

  i2cm_pkg::seq_state_t    st_q, st_d;
  i2cm_pkg::phase_e        tgt;
  logic                    do_enter;
  logic                    finish;
  logic [i2cm_pkg::DelayW-1:0] cnt_dec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: i2cm_pkg::PH_IDLE, cnt: '0, bit_idx: '0, tx: '0, rx: '0,
                scl: 1'b1, sda: 1'b1, cmd: i2cm_pkg::CMD_START, ack_seen: 1'b0,
                ack_to_send: 1'b0, second_byte: 1'b0};
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

  assign busy_o = (st_q.phase != i2cm_pkg::PH_IDLE);

  // Next state: start a command or count the current segment down, then enter
  // the chosen segment, which sets the pins and loads its hold length.
  always_comb begin
    st_d     = st_q;
    tgt      = i2cm_pkg::PH_IDLE;
    do_enter = 1'b0;
    finish   = 1'b0;
    cnt_dec  = (st_q.cnt != '0) ? st_q.cnt - i2cm_pkg::DelayW'(1) : st_q.cnt;

    if (kind_i) begin
      if (st_q.phase == i2cm_pkg::PH_IDLE) begin
        st_d.cmd         = i2cm_pkg::cmd_e'(command_i);
        st_d.second_byte = 1'b0;
        st_d.bit_idx     = '0;
        do_enter         = 1'b1;
        unique case (i2cm_pkg::cmd_e'(command_i))
          i2cm_pkg::CMD_START: tgt = i2cm_pkg::PH_S_SCLHI;
          i2cm_pkg::CMD_START_BYTE: begin
            st_d.tx = {data_i[7:0], 8'h00};
            st_d.ack_seen = 1'b0;
            tgt = i2cm_pkg::PH_S_SCLHI;
          end
          i2cm_pkg::CMD_START_ADDR: begin
            st_d.tx = {address_i, rw_flag_i, 8'h00};
            st_d.ack_seen = 1'b0;
            tgt = i2cm_pkg::PH_S_SCLHI;
          end
          i2cm_pkg::CMD_STOP: tgt = i2cm_pkg::PH_P_SDALO;
          i2cm_pkg::CMD_WRITE: begin
            st_d.tx = {data_i[7:0], 8'h00};
            st_d.ack_seen = 1'b0;
            tgt = i2cm_pkg::PH_W_SCLLO;
          end
          i2cm_pkg::CMD_WRITE_NACK: begin
            st_d.tx = {data_i[7:0], 8'h00};
            tgt = i2cm_pkg::PH_W_SCLLO;
          end
          i2cm_pkg::CMD_WRITE16: begin
            st_d.tx = data_i;
            st_d.ack_seen = 1'b0;
            tgt = i2cm_pkg::PH_W_SCLLO;
          end
          i2cm_pkg::CMD_READ: begin
            st_d.ack_to_send = send_ack_i;
            st_d.rx = '0;
            st_d.sda = 1'b1;
            tgt = i2cm_pkg::PH_R_SCLLO;
          end
          default: tgt = i2cm_pkg::PH_IDLE;
        endcase
      end
    end else if (st_q.phase != i2cm_pkg::PH_IDLE) begin
      st_d.cnt = cnt_dec;
      if (cnt_dec == '0) begin
        do_enter = 1'b1;
        unique case (st_q.phase)
          i2cm_pkg::PH_S_SCLHI: tgt = i2cm_pkg::PH_S_SDALO;
          i2cm_pkg::PH_S_SDALO: begin
            if (st_q.cmd == i2cm_pkg::CMD_START) begin
              finish = 1'b1;
            end else begin
              st_d.bit_idx = '0;
              tgt = i2cm_pkg::PH_W_SCLLO;
            end
          end
          i2cm_pkg::PH_W_SCLLO: tgt = i2cm_pkg::PH_W_DATA;
          i2cm_pkg::PH_W_DATA:  tgt = i2cm_pkg::PH_W_SCLHI;
          i2cm_pkg::PH_W_SCLHI: begin
            st_d.tx      = {st_q.tx[14:0], 1'b0};
            st_d.bit_idx = st_q.bit_idx + 4'd1;
            tgt = (st_d.bit_idx < 4'd8) ? i2cm_pkg::PH_W_SCLLO : i2cm_pkg::PH_W_TAIL;
          end
          i2cm_pkg::PH_W_TAIL: begin
            if (st_q.cmd == i2cm_pkg::CMD_WRITE_NACK) finish = 1'b1;
            else tgt = i2cm_pkg::PH_A_SDAHI;
          end
          i2cm_pkg::PH_A_SDAHI: tgt = i2cm_pkg::PH_A_SCLHI;
          i2cm_pkg::PH_A_SCLHI: tgt = i2cm_pkg::PH_A_SAMPLE;
          i2cm_pkg::PH_A_SAMPLE: begin
            st_d.ack_seen = ~sda_in_i;
            tgt = i2cm_pkg::PH_A_SCLLO;
          end
          i2cm_pkg::PH_A_SCLLO: begin
            // Write16 goes on to the low byte only after an acknowledged high byte.
            if (st_q.cmd == i2cm_pkg::CMD_WRITE16 && !st_q.second_byte && st_q.ack_seen) begin
              st_d.second_byte = 1'b1;
              st_d.bit_idx = '0;
              tgt = i2cm_pkg::PH_W_SCLLO;
            end else begin
              finish = 1'b1;
            end
          end
          i2cm_pkg::PH_P_SDALO: tgt = i2cm_pkg::PH_P_SCLHI;
          i2cm_pkg::PH_P_SCLHI: tgt = i2cm_pkg::PH_P_SDAHI;
          i2cm_pkg::PH_R_SCLLO: tgt = i2cm_pkg::PH_R_SCLHI;
          i2cm_pkg::PH_R_SCLHI: begin
            st_d.rx      = {st_q.rx[6:0], sda_in_i};
            st_d.bit_idx = st_q.bit_idx + 4'd1;
            tgt = (st_d.bit_idx < 4'd8) ? i2cm_pkg::PH_R_SCLLO : i2cm_pkg::PH_R_REL;
          end
          i2cm_pkg::PH_R_REL: begin
            tgt = st_q.ack_to_send ? i2cm_pkg::PH_R_ACK : i2cm_pkg::PH_R_CLKHI;
          end
          i2cm_pkg::PH_R_ACK:   tgt = i2cm_pkg::PH_R_CLKHI;
          i2cm_pkg::PH_R_CLKHI: tgt = i2cm_pkg::PH_R_CLKLO;
          i2cm_pkg::PH_R_CLKLO: begin
            st_d.sda = 1'b1;
            finish = 1'b1;
          end
          default: finish = 1'b1;
        endcase
        if (finish) begin
          do_enter   = 1'b0;
          st_d.phase = i2cm_pkg::PH_IDLE;
          st_d.cnt   = '0;
        end
      end
    end

    if (do_enter) begin
      st_d.phase = tgt;
      st_d.cnt   = hold_i.long_ticks;
      unique case (tgt)
        i2cm_pkg::PH_S_SCLHI:  st_d.scl = 1'b1;
        i2cm_pkg::PH_S_SDALO:  st_d.sda = 1'b0;
        i2cm_pkg::PH_W_SCLLO:  begin st_d.scl = 1'b0; st_d.cnt = hold_i.short_ticks; end
        i2cm_pkg::PH_W_DATA:   begin st_d.sda = st_d.tx[15]; st_d.cnt = hold_i.short_ticks; end
        i2cm_pkg::PH_W_SCLHI:  begin st_d.scl = 1'b1; st_d.cnt = hold_i.bit_ticks; end
        i2cm_pkg::PH_W_TAIL:   begin st_d.scl = 1'b0; st_d.cnt = hold_i.short_ticks; end
        i2cm_pkg::PH_A_SDAHI:  st_d.sda = 1'b1;
        i2cm_pkg::PH_A_SCLHI:  st_d.scl = 1'b1;
        i2cm_pkg::PH_A_SAMPLE: st_d.sda = 1'b1;
        i2cm_pkg::PH_A_SCLLO:  st_d.scl = 1'b0;
        i2cm_pkg::PH_P_SDALO:  st_d.sda = 1'b0;
        i2cm_pkg::PH_P_SCLHI:  begin st_d.scl = 1'b1; st_d.cnt = hold_i.short_ticks; end
        i2cm_pkg::PH_P_SDAHI:  st_d.sda = 1'b1;
        i2cm_pkg::PH_R_SCLLO:  begin st_d.scl = 1'b0; st_d.cnt = hold_i.short_ticks; end
        i2cm_pkg::PH_R_SCLHI:  begin st_d.scl = 1'b1; st_d.cnt = hold_i.bit_ticks; end
        i2cm_pkg::PH_R_REL:    begin st_d.scl = 1'b0; st_d.sda = 1'b1; end
        i2cm_pkg::PH_R_ACK:    st_d.sda = 1'b0;
        i2cm_pkg::PH_R_CLKHI:  st_d.scl = 1'b1;
        i2cm_pkg::PH_R_CLKLO:  st_d.scl = 1'b0;
        default: begin
          st_d.phase = i2cm_pkg::PH_IDLE;
          st_d.cnt   = '0;
        end
      endcase
    end
  end

  // Result of this tick, built from the updated state.
  always_comb begin
    res_o.scl       = st_d.scl;
    res_o.sda       = st_d.sda;
    res_o.busy      = (st_d.phase != i2cm_pkg::PH_IDLE);
    res_o.done      = finish;
    res_o.acked     = st_d.ack_seen;
    res_o.read_byte = st_d.rx;
  end

endmodule

`default_nettype wire

// ===== rtl/i2c_master_bit_engine.sv =====
// Top level of the I2C master bit engine: handshake, result register, assertions.
// Depends on i2cm_pkg, i2cm_cfg, i2cm_seq and i2c_master_bit_engine_assert.svh.
`default_nettype none

// I2C master bit engine. Each accepted input transaction is either one time tick
// or a new command; every transaction produces exactly one result transaction
// holding the SCL and SDA levels to drive (1 = released), the busy and done
// flags, the last acknowledge seen and the last byte read. Commands arriving
// while a sequence runs are ignored and report the current levels. The block
// takes one transaction per clock cycle: the sequencer state is updated by a
// single pass of next-state logic at the accepting edge and the result lands in
// an output register, so the next transaction is accepted while the previous
// result is being taken. Throughput drops only while the result register is
// full and out_ready_i is low. The three delay registers (index 0 short, 1
// long, 2 wait) are written through cfg_we_i, cfg_index_i and cfg_data_i;
// writes to index 3 are dropped. No memory clear is needed after reset.

`include "i2c_master_bit_engine_assert.svh"

module i2c_master_bit_engine (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Configuration write port.
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_index_i,
  input  wire logic [i2cm_pkg::DelayW-1:0] cfg_data_i,
  // Input channel.
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        kind_i,
  input  wire logic [2:0]                  command_i,
  input  wire logic [15:0]                 data_i,
  input  wire logic [6:0]                  address_i,
  input  wire logic                        rw_flag_i,
  input  wire logic                        send_ack_i,
  input  wire logic                        sda_in_i,
  // Result channel.
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             scl_out_o,
  output logic                             sda_out_o,
  output logic                             busy_res_o,
  output logic                             done_res_o,
  output logic                             acked_o,
  output logic [7:0]                       read_byte_o
);

  i2cm_pkg::hold_t hold;
  i2cm_pkg::res_t  res_d, res_q;
  logic            in_accept;
  logic            seq_busy;
  logic            out_valid_q, out_valid_d;

  // The result register frees up in the same cycle its content is taken.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  i2cm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .hold_o      (hold)
  );

  i2cm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (in_accept),
    .kind_i     (kind_i),
    .command_i  (command_i),
    .data_i     (data_i),
    .address_i  (address_i),
    .rw_flag_i  (rw_flag_i),
    .send_ack_i (send_ack_i),
    .sda_in_i   (sda_in_i),
    .hold_i     (hold),
    .res_o      (res_d),
    .busy_o     (seq_busy)
  );

  // A result is pending whenever a transaction was accepted, or the old one
  // has not been taken yet.
  assign out_valid_d = in_accept || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload needs no reset; it is only looked at while out_valid_o is high.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_out_o   = res_q.scl;
  assign sda_out_o   = res_q.sda;
  assign busy_res_o  = res_q.busy;
  assign done_res_o  = res_q.done;
  assign acked_o     = res_q.acked;
  assign read_byte_o = res_q.read_byte;

  // A finishing tick always leaves the sequencer idle.
  `I2CM_ASSERT(a_done_not_busy, out_valid_o && done_res_o |-> !busy_res_o, "done with busy set")
  // A command taken while idle always starts a sequence.
  `I2CM_ASSERT(a_cmd_starts, in_accept && kind_i && !seq_busy |=> out_valid_o && busy_res_o && !done_res_o, "idle command did not start")
  // A tick taken while idle changes nothing and finishes nothing.
  `I2CM_ASSERT(a_idle_tick, in_accept && !kind_i && !seq_busy |=> out_valid_o && !busy_res_o && !done_res_o, "idle tick changed state")
  // With an empty result register the input side is always open.
  `I2CM_ASSERT_ALWAYS(a_ready_when_empty, !out_valid_q |-> in_ready_o, "ready low with empty output")

endmodule

`default_nettype wire

// ===== tb/i2c_master_bit_engine_tb.sv =====
// Self-checking testbench for the I2C master bit engine: directed commands, then random
// traffic under several delay settings. Needs i2cm_pkg and the i2c_master_bit_engine RTL.
// The bench predicts every result from its own model of the bus sequencer.

module i2c_master_bit_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cm_pkg::*;

  // Values of the kind field of an input transaction.
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_CMD  = 1'b1;

  // The port has a fourth index that maps to no register; writes there must be dropped.
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // How the generator picks the SDA level it feeds back on each tick.
  typedef enum logic [1:0] {
    SDA_RAND,
    SDA_LOW,
    SDA_HIGH
  } sda_mode_e;

  // One input transaction together with the result it must produce.
  typedef struct {
    logic        kind;
    cmd_e        command;
    logic [15:0] data;
    logic [6:0]  address;
    logic        rw_flag;
    logic        send_ack;
    logic        sda_in;
    res_t        exp;
  } bus_item_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [1:0]          cfg_index_i = CFG_SHORT;
  logic [DelayW-1:0]   cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic                kind_i      = KIND_TICK;
  logic [2:0]          command_i   = CMD_START;
  logic [15:0]         data_i      = '0;
  logic [6:0]          address_i   = '0;
  logic                rw_flag_i   = 1'b0;
  logic                send_ack_i  = 1'b0;
  logic                sda_in_i    = 1'b1;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                scl_out_o;
  logic                sda_out_o;
  logic                busy_res_o;
  logic                done_res_o;
  logic                acked_o;
  logic [7:0]          read_byte_o;

  i2c_master_bit_engine DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .command_i   (command_i),
    .data_i      (data_i),
    .address_i   (address_i),
    .rw_flag_i   (rw_flag_i),
    .send_ack_i  (send_ack_i),
    .sda_in_i    (sda_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .scl_out_o   (scl_out_o),
    .sda_out_o   (sda_out_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .acked_o     (acked_o),
    .read_byte_o (read_byte_o)
  );

  // 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Transactions waiting to be driven, and the levels still owed by the block.
  bus_item_t   bus_items[$];
  res_t        due_levels[$];

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;

  // Idling limits, changed from phase to phase. Zero turns idling off on that side.
  int unsigned gap_max   = 0;
  int unsigned stall_max = 0;
  int unsigned gap_left  = 0;
  int unsigned stall_left = 0;

  // Handshake outcomes captured at the rising edge, consumed at the next falling edge.
  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;

  // ---------------------------------------------------------------------------
  // Sequencer model. The delay registers and the engine state live here; the
  // generator advances it as it queues each transaction, which matches the
  // acceptance order since the queue is strictly first in, first out.
  // ---------------------------------------------------------------------------
  logic [15:0] dly_short = SHORT_RESET;
  logic [15:0] dly_long  = LONG_RESET;
  logic [15:0] dly_wait  = WAIT_RESET;

  phase_e      eng_phase   = PH_IDLE;
  logic [15:0] eng_cnt     = '0;
  logic [3:0]  eng_bit     = '0;
  logic [15:0] eng_tx      = '0;
  logic [7:0]  eng_rx      = '0;
  logic        eng_scl     = 1'b1;
  logic        eng_sda     = 1'b1;
  cmd_e        eng_cmd     = CMD_START;
  logic        eng_ack     = 1'b0;
  logic        eng_ack_out = 1'b0;
  logic        eng_second  = 1'b0;

  // A programmed hold of zero still lasts one tick.
  function automatic logic [15:0] short_hold();
    return (dly_short == '0) ? 16'd1 : dly_short;
  endfunction

  function automatic logic [15:0] long_hold();
    return (dly_long == '0) ? 16'd1 : dly_long;
  endfunction

  // The SCL-high part of a data bit is short plus wait, clipped to the counter width.
  function automatic logic [15:0] bit_hold();
    logic [16:0] sum;
    sum = {1'b0, short_hold()} + {1'b0, dly_wait};
    return sum[16] ? 16'hFFFF : sum[15:0];
  endfunction

  // Entering a segment sets its pin levels and loads its hold length.
  function automatic void enter_segment(phase_e p);
    logic [15:0] d;
    d = long_hold();
    eng_phase = p;
    case (p)
      PH_S_SCLHI:  eng_scl = 1'b1;
      PH_S_SDALO:  eng_sda = 1'b0;
      PH_W_SCLLO: begin
        eng_scl = 1'b0;
        d = short_hold();
      end
      PH_W_DATA: begin
        eng_sda = eng_tx[15];
        d = short_hold();
      end
      PH_W_SCLHI: begin
        eng_scl = 1'b1;
        d = bit_hold();
      end
      PH_W_TAIL: begin
        eng_scl = 1'b0;
        d = short_hold();
      end
      PH_A_SDAHI:  eng_sda = 1'b1;
      PH_A_SCLHI:  eng_scl = 1'b1;
      PH_A_SAMPLE: eng_sda = 1'b1;
      PH_A_SCLLO:  eng_scl = 1'b0;
      PH_P_SDALO:  eng_sda = 1'b0;
      PH_P_SCLHI: begin
        eng_scl = 1'b1;
        d = short_hold();
      end
      PH_P_SDAHI:  eng_sda = 1'b1;
      PH_R_SCLLO: begin
        eng_scl = 1'b0;
        d = short_hold();
      end
      PH_R_SCLHI: begin
        eng_scl = 1'b1;
        d = bit_hold();
      end
      PH_R_REL: begin
        eng_scl = 1'b0;
        eng_sda = 1'b1;
      end
      PH_R_ACK:    eng_sda = 1'b0;
      PH_R_CLKHI:  eng_scl = 1'b1;
      PH_R_CLKLO:  eng_scl = 1'b0;
      default: begin
        eng_phase = PH_IDLE;
        d = '0;
      end
    endcase
    eng_cnt = d;
  endfunction

  // Ends the running segment, taking any sample due now. Returns 1 when the
  // whole command sequence is over.
  function automatic logic close_segment(logic sda);
    case (eng_phase)
      PH_S_SCLHI: begin
        enter_segment(PH_S_SDALO);
        return 1'b0;
      end
      PH_S_SDALO: begin
        // A bare start ends here; start with byte or address goes on to the byte.
        if (eng_cmd != CMD_START) begin
          eng_bit = '0;
          enter_segment(PH_W_SCLLO);
          return 1'b0;
        end
      end
      PH_W_SCLLO: begin
        enter_segment(PH_W_DATA);
        return 1'b0;
      end
      PH_W_DATA: begin
        enter_segment(PH_W_SCLHI);
        return 1'b0;
      end
      PH_W_SCLHI: begin
        eng_tx  = {eng_tx[14:0], 1'b0};
        eng_bit = eng_bit + 4'd1;
        if (eng_bit < 4'd8) begin
          enter_segment(PH_W_SCLLO);
        end else begin
          enter_segment(PH_W_TAIL);
        end
        return 1'b0;
      end
      PH_W_TAIL: begin
        if (eng_cmd != CMD_WRITE_NACK) begin
          enter_segment(PH_A_SDAHI);
          return 1'b0;
        end
      end
      PH_A_SDAHI: begin
        enter_segment(PH_A_SCLHI);
        return 1'b0;
      end
      PH_A_SCLHI: begin
        enter_segment(PH_A_SAMPLE);
        return 1'b0;
      end
      PH_A_SAMPLE: begin
        eng_ack = ~sda;
        enter_segment(PH_A_SCLLO);
        return 1'b0;
      end
      PH_A_SCLLO: begin
        // A 16-bit write sends its low byte only after the high byte was acknowledged.
        if (eng_cmd == CMD_WRITE16 && !eng_second && eng_ack) begin
          eng_second = 1'b1;
          eng_bit = '0;
          enter_segment(PH_W_SCLLO);
          return 1'b0;
        end
      end
      PH_P_SDALO: begin
        enter_segment(PH_P_SCLHI);
        return 1'b0;
      end
      PH_P_SCLHI: begin
        enter_segment(PH_P_SDAHI);
        return 1'b0;
      end
      PH_R_SCLLO: begin
        enter_segment(PH_R_SCLHI);
        return 1'b0;
      end
      PH_R_SCLHI: begin
        eng_rx  = {eng_rx[6:0], sda};
        eng_bit = eng_bit + 4'd1;
        if (eng_bit < 4'd8) begin
          enter_segment(PH_R_SCLLO);
        end else begin
          enter_segment(PH_R_REL);
        end
        return 1'b0;
      end
      PH_R_REL: begin
        if (eng_ack_out) begin
          enter_segment(PH_R_ACK);
        end else begin
          enter_segment(PH_R_CLKHI);
        end
        return 1'b0;
      end
      PH_R_ACK: begin
        enter_segment(PH_R_CLKHI);
        return 1'b0;
      end
      PH_R_CLKHI: begin
        enter_segment(PH_R_CLKLO);
        return 1'b0;
      end
      PH_R_CLKLO: eng_sda = 1'b1;
      default: ;
    endcase
    eng_phase = PH_IDLE;
    eng_cnt = '0;
    return 1'b1;
  endfunction

  // Starts a command from idle. Only the byte-sending commands other than a write
  // without acknowledge clear the acknowledge flag, and only a read clears the received byte.
  function automatic void start_command(bus_item_t it);
    eng_cmd    = it.command;
    eng_second = 1'b0;
    eng_bit    = '0;
    case (it.command)
      CMD_START: enter_segment(PH_S_SCLHI);
      CMD_START_BYTE: begin
        eng_tx  = {it.data[7:0], 8'h00};
        eng_ack = 1'b0;
        enter_segment(PH_S_SCLHI);
      end
      CMD_START_ADDR: begin
        eng_tx  = {it.address, it.rw_flag, 8'h00};
        eng_ack = 1'b0;
        enter_segment(PH_S_SCLHI);
      end
      CMD_STOP: enter_segment(PH_P_SDALO);
      CMD_WRITE: begin
        eng_tx  = {it.data[7:0], 8'h00};
        eng_ack = 1'b0;
        enter_segment(PH_W_SCLLO);
      end
      CMD_WRITE_NACK: begin
        eng_tx = {it.data[7:0], 8'h00};
        enter_segment(PH_W_SCLLO);
      end
      CMD_WRITE16: begin
        eng_tx  = it.data;
        eng_ack = 1'b0;
        enter_segment(PH_W_SCLLO);
      end
      default: begin
        eng_ack_out = it.send_ack;
        eng_rx  = '0;
        eng_sda = 1'b1;
        enter_segment(PH_R_SCLLO);
      end
    endcase
  endfunction

  // Advances the model by one transaction and returns the levels it must show.
  // Commands while busy and ticks while idle change nothing.
  function automatic res_t step_engine(bus_item_t it);
    res_t r;
    logic fin;
    fin = 1'b0;
    if (it.kind == KIND_CMD) begin
      if (eng_phase == PH_IDLE) begin
        start_command(it);
      end
    end else if (eng_phase != PH_IDLE) begin
      if (eng_cnt != '0) begin
        eng_cnt = eng_cnt - 16'd1;
      end
      if (eng_cnt == '0) begin
        fin = close_segment(it.sda_in);
      end
    end
    r.scl       = eng_scl;
    r.sda       = eng_sda;
    r.busy      = (eng_phase != PH_IDLE);
    r.done      = fin;
    r.acked     = eng_ack;
    r.read_byte = eng_rx;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking.
  // ---------------------------------------------------------------------------

  // One line per failure, and the count goes up with each.
  task automatic report_failure(string msg);
    mismatches++;
    $display("[%0t] result %0d: %s", $time, results_seen, msg);
  endtask

  // Both handshakes are sampled at the rising edge. An accepted input transaction
  // moves its expected levels into due_levels; an accepted result is checked
  // against the oldest entry there.
  always @(posedge clk_i) begin : sample_ports
    res_t want;
    in_taken  <= rst_ni && in_valid_i && in_ready_o;
    out_taken <= rst_ni && out_valid_o && out_ready_i;
    if (rst_ni && in_valid_i && in_ready_o) begin
      due_levels.push_back(bus_items[0].exp);
      bus_items.delete(0);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (due_levels.size() == 0) begin
        report_failure("result transaction arrived with nothing expected");
      end else begin
        want = due_levels.pop_front();
        if (scl_out_o !== want.scl) begin
          report_failure($sformatf("scl_out %b, expected %b", scl_out_o, want.scl));
        end
        if (sda_out_o !== want.sda) begin
          report_failure($sformatf("sda_out %b, expected %b", sda_out_o, want.sda));
        end
        if (busy_res_o !== want.busy) begin
          report_failure($sformatf("busy_res %b, expected %b", busy_res_o, want.busy));
        end
        if (done_res_o !== want.done) begin
          report_failure($sformatf("done_res %b, expected %b", done_res_o, want.done));
        end
        if (acked_o !== want.acked) begin
          report_failure($sformatf("acked %b, expected %b", acked_o, want.acked));
        end
        if (read_byte_o !== want.read_byte) begin
          report_failure($sformatf("read_byte %h, expected %h", read_byte_o,
                                   want.read_byte));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver and result sink, both working on the falling edge.
  // ---------------------------------------------------------------------------

  // The driver presents the head of bus_items and holds it until accepted. Before
  // each new transaction it may idle for a drawn number of cycles.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (bus_items.size() != 0) begin
        in_valid_i <= 1'b1;
        kind_i     <= bus_items[0].kind;
        command_i  <= bus_items[0].command;
        data_i     <= bus_items[0].data;
        address_i  <= bus_items[0].address;
        rw_flag_i  <= bus_items[0].rw_flag;
        send_ack_i <= bus_items[0].send_ack;
        sda_in_i   <= bus_items[0].sda_in;
        gap_left   <= $urandom_range(0, gap_max);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // After each accepted result the sink may hold ready low for a drawn number of cycles.
  always @(negedge clk_i) begin : result_sink
    int unsigned n;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (out_taken) begin
      n = $urandom_range(0, stall_max);
      if (n != 0) begin
        out_ready_i <= 1'b0;
        stall_left  <= n - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end else if (!out_ready_i) begin
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Predicts the transaction, then queues it once there is room.
  task automatic queue_item(logic kind, cmd_e c, logic [15:0] d, logic [6:0] a,
                            logic rw, logic ack, logic sda);
    bus_item_t it;
    it.kind     = kind;
    it.command  = c;
    it.data     = d;
    it.address  = a;
    it.rw_flag  = rw;
    it.send_ack = ack;
    it.sda_in   = sda;
    it.exp      = step_engine(it);
    while (bus_items.size() >= 4) @(negedge clk_i);
    bus_items.push_back(it);
  endtask

  // A tick carries random values in the command fields; the block must ignore them.
  task automatic tick(logic sda);
    queue_item(KIND_TICK, cmd_e'($urandom_range(0, 7)), 16'($urandom), 7'($urandom),
               1'($urandom), 1'($urandom), sda);
  endtask

  task automatic issue(cmd_e c, logic [15:0] d, logic [6:0] a, logic rw, logic ack);
    queue_item(KIND_CMD, c, d, a, rw, ack, 1'($urandom));
  endtask

  task automatic issue_random();
    issue(cmd_e'($urandom_range(0, 7)), 16'($urandom), 7'($urandom), 1'($urandom),
          1'($urandom));
  endtask

  function automatic logic pick_sda(sda_mode_e m);
    case (m)
      SDA_LOW:  return 1'b0;
      SDA_HIGH: return 1'b1;
      default:  return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // Ticks the running command through to its end.
  task automatic finish_command(sda_mode_e m);
    while (eng_phase != PH_IDLE) tick(pick_sda(m));
  endtask

  task automatic run_command(cmd_e c, logic [15:0] d, logic [6:0] a, logic rw,
                             logic ack, sda_mode_e m);
    issue(c, d, a, rw, ack);
    finish_command(m);
  endtask

  // Returns at a falling edge once every queued transaction has been accepted
  // and every expected result has been taken.
  task automatic wait_drained();
    while (bus_items.size() != 0 || due_levels.size() != 0) @(negedge clk_i);
  endtask

  // Register writes go in only with nothing in flight. The engine itself may still
  // be inside a sequence; the new value then applies from the next segment on.
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      CFG_SHORT: dly_short = val;
      CFG_LONG:  dly_long  = val;
      CFG_WAIT:  dly_wait  = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_delays(logic [15:0] s, logic [15:0] l, logic [15:0] w);
    write_reg(CFG_SHORT, s);
    write_reg(CFG_LONG, l);
    write_reg(CFG_WAIT, w);
  endtask

  // Random traffic that mostly issues commands from idle and then ticks them
  // through with random SDA; the last sequence may still run when n is reached.
  // Noise is mixed in: ticks while idle, commands while busy, and some full
  // pauses before a command. Only transactions that matter to the engine count toward n.
  task automatic random_traffic(int unsigned n);
    int unsigned counted;
    counted = 0;
    while (counted < n) begin
      if (eng_phase == PH_IDLE) begin
        case ($urandom_range(0, 9))
          0: tick(pick_sda(SDA_RAND));
          1: begin
            wait_drained();
            issue_random();
            counted++;
          end
          default: begin
            issue_random();
            counted++;
          end
        endcase
      end else if ($urandom_range(0, 24) == 0) begin
        issue_random();
      end else begin
        tick(pick_sda(SDA_RAND));
        counted++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    gap_max   = 8;
    stall_max = 8;

    // Directed part, first on the reset delays. A tick while idle must change nothing.
    tick(1'b0);
    run_command(CMD_START, 16'h0000, 7'h00, 1'b0, 1'b0, SDA_RAND);
    // Highest address with the read flag, acknowledged. A second command right
    // after the first tick lands while busy and must be ignored.
    issue(CMD_START_ADDR, 16'h0000, 7'h7F, 1'b1, 1'b0);
    tick(1'b0);
    issue(CMD_STOP, 16'hFFFF, 7'h00, 1'b0, 1'b1);
    finish_command(SDA_LOW);
    run_command(CMD_STOP, 16'h0000, 7'h00, 1'b0, 1'b0, SDA_RAND);
    // The rest of the directed commands run on the shortest holds.
    set_delays(16'd1, 16'd1, 16'd0);
    // Only the low byte goes out for 8-bit commands.
    run_command(CMD_START_BYTE, 16'hFF00, 7'h2A, 1'b0, 1'b0, SDA_HIGH);
    run_command(CMD_WRITE16, 16'hFFFF, 7'h00, 1'b0, 1'b0, SDA_LOW);
    // High byte not acknowledged: the 16-bit write stops after one slot.
    run_command(CMD_WRITE16, 16'h0000, 7'h00, 1'b0, 1'b0, SDA_HIGH);
    run_command(CMD_WRITE_NACK, 16'h00A5, 7'h00, 1'b0, 1'b0, SDA_HIGH);
    run_command(CMD_WRITE, 16'h005A, 7'h00, 1'b0, 1'b0, SDA_LOW);
    run_command(CMD_WRITE, 16'h00FF, 7'h00, 1'b0, 1'b0, SDA_HIGH);
    run_command(CMD_READ, 16'h0000, 7'h00, 1'b0, 1'b1, SDA_HIGH);
    run_command(CMD_READ, 16'hFFFF, 7'h7F, 1'b1, 1'b0, SDA_LOW);
    run_command(CMD_START_ADDR, 16'hFFFF, 7'h00, 1'b0, 1'b1, SDA_RAND);

    // All delays zero: every hold still lasts one tick. No idling on either side.
    set_delays(16'd0, 16'd0, 16'd0);
    gap_max   = 0;
    stall_max = 0;
    random_traffic(70);

    // A write to the unused index must leave the delays alone.
    write_reg(CFG_UNUSED, 16'($urandom));

    // Several small random settings. Each change may land in the middle of a
    // sequence, since the previous phase stops wherever its count runs out.
    for (int p = 0; p < 5; p++) begin
      set_delays(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                 16'($urandom_range(0, 3)));
      gap_max   = (p == 3) ? 0 : 8;
      stall_max = (p == 1) ? 0 : 8;
      random_traffic(70);
    end

    // Register changes between the segments of a running sequence, idling off.
    finish_command(SDA_RAND);
    gap_max   = 0;
    stall_max = 0;
    // A long SCL-high hold on the first read bit. After that bit the wait goes
    // back to zero while the read is still running.
    set_delays(16'd1, 16'd1, 16'd40);
    issue(CMD_READ, 16'($urandom), 7'($urandom), 1'($urandom), 1'($urandom));
    while (eng_bit == 4'd0) tick(pick_sda(SDA_RAND));
    write_reg(CFG_WAIT, 16'd0);
    finish_command(SDA_RAND);
    // A long first stop segment, shortened again before the next one.
    write_reg(CFG_LONG, 16'd40);
    issue(CMD_STOP, 16'($urandom), 7'($urandom), 1'($urandom), 1'($urandom));
    while (eng_phase == PH_P_SDALO) tick(pick_sda(SDA_RAND));
    write_reg(CFG_LONG, 16'd1);
    finish_command(SDA_RAND);
    // Top short and wait values with a start, which only uses the long hold.
    set_delays(16'hFFFF, 16'd1, 16'hFFFF);
    run_command(CMD_START, 16'($urandom), 7'($urandom), 1'($urandom), 1'($urandom),
                SDA_RAND);

    // Back to small delays for a last stretch with idling on both sides.
    set_delays(16'd1, 16'd2, 16'd1);
    gap_max   = 8;
    stall_max = 8;
    random_traffic(70);

    // Let the last results drain, then keep watching the output register in case
    // anything extra comes out.
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: the whole run takes well under a millisecond of simulated time.
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
